[hdl/tab_pkg.sv]
package tab_pkg;

  localparam int unsigned ChanWidth   = 8;
  localparam int unsigned NumChan     = 4;
  localparam int unsigned PixWidth    = ChanWidth * NumChan;
  localparam int unsigned TintWidth   = 9;
  localparam int unsigned FxWidth     = 16;
  localparam int unsigned CfgIdxWidth = 3;

  // lane of the alpha byte inside an ARGB word
  localparam int unsigned AlphaLane = 3;

  localparam logic [TintWidth-1:0] TintOne     = 9'd256;
  localparam logic [FxWidth-1:0]   AlphaFullFx = 16'd65280;  // 255 * 256
  localparam logic [ChanWidth-1:0] ChanMax     = 8'hFF;

  typedef logic [ChanWidth-1:0] chan_t;
  typedef logic [PixWidth-1:0]  pix_t;
  typedef logic [TintWidth-1:0] tint_t;
  typedef logic [FxWidth-1:0]   fx_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    TAB_REG_RED   = 3'd0,
    TAB_REG_GREEN = 3'd1,
    TAB_REG_BLUE  = 3'd2,
    TAB_REG_ALPHA = 3'd3
  } tab_reg_e;

  // controls for the two divide stages of one lane
  typedef struct packed {
    logic ld_x;   // load partial quotient stage
    logic ld_q;   // load output stage
    logic chk;    // partial quotient stage holds a live request
  } tab_div_ctrl_t;

endpackage

[hdl/tab_in_if.sv]
interface tab_in_if;
  logic          valid;
  logic          ready;
  tab_pkg::pix_t source_pixel;
  tab_pkg::pix_t dest_pixel;

  modport source (output valid, output source_pixel, output dest_pixel, input ready);
  modport sink   (input valid, input source_pixel, input dest_pixel, output ready);
endinterface

[hdl/tab_out_if.sv]
interface tab_out_if;
  logic          valid;
  logic          ready;
  tab_pkg::pix_t blended_pixel;

  modport source (output valid, output blended_pixel, input ready);
  modport sink   (input valid, input blended_pixel, output ready);
endinterface

[hdl/tab_tint.sv]
// Stage 1: per-lane tint multiply, destination bytes carried along.
module tab_tint (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  tab_pkg::pix_t                        src_i,
  input  tab_pkg::pix_t                        dst_i,
  input  tab_pkg::tint_t [tab_pkg::NumChan-1:0] tint_i,
  output tab_pkg::fx_t   [tab_pkg::NumChan-1:0] ts_o,
  output tab_pkg::chan_t [tab_pkg::NumChan-1:0] d_o
);

  localparam int unsigned ProdWidth = tab_pkg::ChanWidth + tab_pkg::TintWidth;

  tab_pkg::fx_t   [tab_pkg::NumChan-1:0] ts_d, ts_q;
  tab_pkg::chan_t [tab_pkg::NumChan-1:0] d_d, d_q;
  logic [tab_pkg::NumChan-1:0][ProdWidth-1:0] prod;

  always_comb begin
    for (int i = 0; i < tab_pkg::NumChan; i++) begin
      prod[i] = ProdWidth'(src_i[i*tab_pkg::ChanWidth +: tab_pkg::ChanWidth])
              * ProdWidth'(tint_i[i]);
      ts_d[i] = prod[i][tab_pkg::FxWidth-1:0];  // at most 255 * 256
      d_d[i]  = dst_i[i*tab_pkg::ChanWidth +: tab_pkg::ChanWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ts_q <= ts_d;
      d_q  <= d_d;
    end
  end

  assign ts_o = ts_q;
  assign d_o  = d_q;

endmodule

[hdl/tab_mix.sv]
// Stage 2: the two products of dst*256*(65280-ta) + ts*ta (the *256 is applied later).
module tab_mix (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  tab_pkg::fx_t   [tab_pkg::NumChan-1:0] ts_i,
  input  tab_pkg::chan_t [tab_pkg::NumChan-1:0] d_i,
  output logic [tab_pkg::NumChan-1:0][tab_pkg::ChanWidth+tab_pkg::FxWidth-1:0] p1_o,
  output logic [tab_pkg::NumChan-1:0][2*tab_pkg::FxWidth-1:0]                  p2_o
);

  localparam int unsigned P1Width = tab_pkg::ChanWidth + tab_pkg::FxWidth;
  localparam int unsigned P2Width = 2 * tab_pkg::FxWidth;

  tab_pkg::fx_t ta;
  tab_pkg::fx_t inv;
  logic [tab_pkg::NumChan-1:0][P1Width-1:0] p1_d, p1_q;
  logic [tab_pkg::NumChan-1:0][P2Width-1:0] p2_d, p2_q;

  assign ta  = ts_i[tab_pkg::AlphaLane];
  assign inv = tab_pkg::AlphaFullFx - ta;   // ta never exceeds 65280

  always_comb begin
    for (int i = 0; i < tab_pkg::NumChan; i++) begin
      p1_d[i] = P1Width'(d_i[i]) * P1Width'(inv);
      p2_d[i] = P2Width'(ts_i[i]) * P2Width'(ta);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  assign p1_o = p1_q;
  assign p2_o = p2_q;

endmodule

[hdl/tab_div255.sv]
// Stages 3 and 4 of one lane: floor(num / (255 * 65536)).
// num >> 16 first, then divide by 255 via x/256 * (1 + 1/256) estimate
// which is low by at most one; one compare fixes it.
module tab_div255 (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  tab_pkg::tab_div_ctrl_t                              ctrl_i,
  input  logic [tab_pkg::ChanWidth+tab_pkg::FxWidth-1:0]      p1_i,
  input  logic [2*tab_pkg::FxWidth-1:0]                       p2_i,
  output tab_pkg::chan_t                                      q_o
);

  localparam int unsigned NumWidth = 2 * tab_pkg::FxWidth + 1;
  localparam int unsigned XWidth   = NumWidth - tab_pkg::FxWidth;
  localparam int unsigned EWidth   = XWidth - tab_pkg::ChanWidth + 1;
  localparam int unsigned RWidth   = XWidth + 1;
  localparam int unsigned QWidth   = EWidth + 1;

  logic [NumWidth-1:0] num;
  logic [XWidth:0]     x_sum;
  logic [XWidth-1:0]   x_d, x_q;
  logic [EWidth-1:0]   e_d, e_q;
  logic [RWidth-1:0]   r;
  logic [QWidth-1:0]   q_raw;
  tab_pkg::chan_t      q_d, q_q;

  assign num   = NumWidth'({p1_i, 8'b0}) + NumWidth'(p2_i);
  assign x_d   = num[NumWidth-1:tab_pkg::FxWidth];
  assign x_sum = (XWidth+1)'(x_d) + (XWidth+1)'(x_d >> tab_pkg::ChanWidth);
  assign e_d   = x_sum[XWidth:tab_pkg::ChanWidth];

  // remainder x - 255*e
  assign r     = RWidth'(x_q) - ((RWidth'(e_q) << tab_pkg::ChanWidth) - RWidth'(e_q));
  assign q_raw = QWidth'(e_q) + QWidth'(r >= RWidth'(tab_pkg::ChanMax));
  assign q_d   = (q_raw > QWidth'(tab_pkg::ChanMax)) ? tab_pkg::ChanMax : q_raw[7:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_x) begin
      x_q <= x_d;
      e_q <= e_d;
    end
    if (ctrl_i.ld_q) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

  // estimate is never more than one below the true quotient
  a_single_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.chk |-> r < RWidth'(2 * 255))
    else $error("divide estimate off by more than one");

  // blend result is a convex mix, never above 255
  a_no_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.chk |-> q_raw <= QWidth'(tab_pkg::ChanMax))
    else $error("blend quotient out of channel range");

endmodule

[hdl/tinted_alpha_blend_pixel.sv]
// Tinted source-over blend, one ARGB8888 pixel per clock unless stalled. Each
// source byte is scaled by its tint register (256 = 1.0, writes above 256
// saturate to 256), and every output byte, alpha included, is floor(dst +
// (ts - dst) * ta/255) computed exactly. A request passes four register
// stages: tint multiply, blend products, partial quotient, output register. The
// result is offered from the output register and taken when the sink is ready.
// One request is taken every cycle unless the pipeline is full and stalled; each
// stage holds its data while the stage after it is full and stalled, and empty
// stages fill behind a stall, so up to four requests wait inside. src_i.ready
// follows res_o.ready through the stage ready chain. Tint registers are written
// through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while
// no request is in flight (not enforced here); unused indexes are ignored.
module tinted_alpha_blend_pixel (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tab_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  tab_pkg::tint_t                     cfg_data_i,
  tab_in_if.sink                             src_i,
  tab_out_if.source                          res_o
);

  localparam int unsigned NumStages = 4;
  localparam int unsigned P1Width   = tab_pkg::ChanWidth + tab_pkg::FxWidth;
  localparam int unsigned P2Width   = 2 * tab_pkg::FxWidth;

  // tint registers, stored already saturated, in byte-lane order (B, G, R, A)
  tab_pkg::tint_t [tab_pkg::NumChan-1:0] tint_q, tint_d;
  tab_pkg::tint_t                        cfg_sat;

  // per-stage valid bits and advance strobes
  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] adv;

  tab_pkg::fx_t   [tab_pkg::NumChan-1:0] ts;
  tab_pkg::chan_t [tab_pkg::NumChan-1:0] dch;
  logic [tab_pkg::NumChan-1:0][P1Width-1:0] p1;
  logic [tab_pkg::NumChan-1:0][P2Width-1:0] p2;
  tab_pkg::chan_t [tab_pkg::NumChan-1:0] q;
  tab_pkg::tab_div_ctrl_t                div_ctrl;

  // ---- configuration ----
  assign cfg_sat = (cfg_data_i > tab_pkg::TintOne) ? tab_pkg::TintOne : cfg_data_i;

  always_comb begin
    tint_d = tint_q;
    if (cfg_we_i) begin
      unique case (tab_pkg::tab_reg_e'(cfg_idx_i))
        tab_pkg::TAB_REG_RED:   tint_d[2] = cfg_sat;
        tab_pkg::TAB_REG_GREEN: tint_d[1] = cfg_sat;
        tab_pkg::TAB_REG_BLUE:  tint_d[0] = cfg_sat;
        tab_pkg::TAB_REG_ALPHA: tint_d[3] = cfg_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_q <= {tab_pkg::NumChan{tab_pkg::TintOne}};
    end else begin
      tint_q <= tint_d;
    end
  end

  // ---- pipeline control ----
  // a stage loads when it is empty or its contents move on this cycle
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || res_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? src_i.valid : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign src_i.ready = adv[0];

  assign div_ctrl.ld_x = adv[2];
  assign div_ctrl.ld_q = adv[3];
  assign div_ctrl.chk  = vld_q[2];

  // ---- datapath ----
  tab_tint u_tint (
    .clk_i  (clk_i),
    .en_i   (adv[0]),
    .src_i  (src_i.source_pixel),
    .dst_i  (src_i.dest_pixel),
    .tint_i (tint_q),
    .ts_o   (ts),
    .d_o    (dch)
  );

  tab_mix u_mix (
    .clk_i (clk_i),
    .en_i  (adv[1]),
    .ts_i  (ts),
    .d_i   (dch),
    .p1_o  (p1),
    .p2_o  (p2)
  );

  for (genvar i = 0; i < tab_pkg::NumChan; i++) begin : g_lane
    tab_div255 u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (div_ctrl),
      .p1_i   (p1[i]),
      .p2_i   (p2[i]),
      .q_o    (q[i])
    );
  end

  assign res_o.valid         = vld_q[NumStages-1];
  assign res_o.blended_pixel = q;

  // ---- checks ----
  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_i.valid && src_i.ready |=> vld_q[0])
    else $error("taken request missing from first stage");

  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !adv[1] |=> vld_q[0])
    else $error("stalled first stage dropped its request");

  a_hold_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !adv[2] |=> vld_q[1])
    else $error("stalled product stage dropped its request");

  a_hold_s3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !adv[3] |=> vld_q[2] && $stable(vld_q[3]))
    else $error("stalled quotient stage lost state");

endmodule
